FILE: hdl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and codes for the strict priority multi-queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int TID_W        = 16;
   localparam int PRIO_W       = 4;
   localparam int FUNC_W       = 2;
   localparam int LEVELS_CSR_W = 4;
   localparam logic [LEVELS_CSR_W-1:0] LEVELS_RESET = 4'd8;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_FULL,
      ST_BAD_LEVEL
   } status_type;

   typedef enum logic {
      BE_IDLE,
      BE_LOOK
   } be_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PRIO_W-1:0] priority_req;
      logic [TID_W-1:0]  task_id;
   } req_word_type;

   typedef struct packed {
      logic [TID_W-1:0] head_task;
      logic [3:0]       head_priority;
      logic [7:0]       total_count;
      logic [4:0]       level_count;
      logic [1:0]       status;
   } rsp_word_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type            op;
      logic              prio_ok;
      logic [PRIO_W-1:0] lvl;
      logic [TID_W-1:0]  tid;
   } cmd_type;

endpackage

FILE: hdl/strict_priority_multi_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// One task fifo per priority level with strict-priority removal.
// ----------------------------------------------------------------------------
// usage
//   request side is a queue: drive req_word and req_push, a word is taken on
//   a rising edge with req_push high and req_full low
//   result side is a queue: rsp_word is valid while rsp_empty is low, a word
//   is taken on a rising edge with rsp_pop high
//   every request word gives exactly one result word, in request order
//   csr_we/csr_wdata set the number of levels in use, write only when idle
// steps
//   a request passes the command queue, exec, look and the result register
//   into the result queue; one command at a time, and only with room in the
//   result queue: exec updates pointers and writes the task store, look
//   picks the top level and reads its head from the single read port
// reset
//   synchronous, clears all queues, counts and both word queues, and sets
//   levels in use to 8; the task store itself is not cleared
// stalls
//   when rsp_pop stays low, up to two results wait and two more requests
//   queue at the front before req_full rises
// ----------------------------------------------------------------------------
module strict_priority_multi_queue
   import spmq_pkg::*;
#(
   parameter int LEVELS    = 8,
   parameter int DEPTH     = 16,
   parameter int TASK_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request word queue
   input  logic                    req_push,
   output logic                    req_full,
   input  req_word_type            req_word,
   // result word queue
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rsp_word_type            rsp_word,
   // levels-in-use register
   input  logic                    csr_we,
   input  logic [LEVELS_CSR_W-1:0] csr_wdata
);

   localparam int ACT_W     = $clog2(LEVELS+1);
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 2;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);
   localparam int RSP_W     = $bits(rsp_word_type);

   logic [LEVELS_CSR_W-1:0] levels_ff, levels_in;
   logic [ACT_W-1:0]        active_levels;

   logic                    cmd_pop;
   logic                    cmd_empty;
   cmd_type                 cmd_word;

   logic                    out_push;
   rsp_word_type            out_word;
   logic                    out_full;
   logic [OUT_CNT_W-1:0]    out_count;
   logic [RSP_W-1:0]        rsp_bits;

   // config register, the user must write it only while idle; the block does not enforce this
   assign levels_in = csr_we ? csr_wdata : levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   // levels in use, clamped to what is built
   assign active_levels = (32'(levels_ff) > LEVELS) ? ACT_W'(LEVELS)
                                                    : ACT_W'(levels_ff);

   // front: take and classify request words
   spmq_front #(
      .LEVELS    (LEVELS),
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .active_levels (active_levels),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_word      (req_word),
      .cmd_pop       (cmd_pop),
      .cmd_empty     (cmd_empty),
      .cmd_word      (cmd_word)
   );

   // back: queue state, task store and result building
   spmq_back #(
      .LEVELS    (LEVELS),
      .DEPTH     (DEPTH),
      .TASK_BITS (TASK_BITS),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .active_levels (active_levels),
      .cmd_empty     (cmd_empty),
      .cmd_word      (cmd_word),
      .cmd_pop       (cmd_pop),
      .out_count     (out_count),
      .rsp_push      (out_push),
      .rsp_word      (out_word)
   );

   // result words wait here; the back end only starts with room reserved
   spmq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && !out_full),
      .push_data (out_word),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_word = rsp_word_type'(rsp_bits);

endmodule

FILE: hdl/spmq_fifo.sv
// ----------------------------------------------------------------------------
// spmq_fifo
// Small register fifo with occupancy count.
// ----------------------------------------------------------------------------
module spmq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/spmq_front.sv
// ----------------------------------------------------------------------------
// spmq_front
// Accepts request words, decodes the function and checks the level.
// ----------------------------------------------------------------------------
module spmq_front
   import spmq_pkg::*;
#(
   parameter int LEVELS    = 8,
   parameter int CMD_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(LEVELS+1)-1:0]  active_levels,
   input  logic                         req_push,
   output logic                         req_full,
   input  req_word_type                 req_word,
   input  logic                         cmd_pop,
   output logic                         cmd_empty,
   output cmd_type                      cmd_word
);

   localparam int CMD_W = $bits(cmd_type);

   cmd_type                          cmd_new;
   logic [CMD_W-1:0]                 cmd_bits;
   logic [$clog2(CMD_DEPTH+1)-1:0]   cmd_count;

   always_comb begin
      cmd_new.prio_ok = (req_word.priority_req != '0) &&
                        (32'(req_word.priority_req) <= 32'(active_levels));
      cmd_new.lvl     = cmd_new.prio_ok ? req_word.priority_req - 1'b1 : '0;
      cmd_new.tid     = req_word.task_id;
      if (req_word.func == FUNC_ADD) begin
         cmd_new.op = OP_ADD;
      end else if (req_word.func == FUNC_REMOVE) begin
         cmd_new.op = OP_REMOVE;
      end else begin
         // unused code is a plain query
         cmd_new.op = OP_QUERY;
      end
   end

   spmq_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_new),
      .pop       (cmd_pop),
      .pop_data  (cmd_bits),
      .full      (req_full),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // occupancy not needed on this side beyond full/empty
   assign cmd_word = cmd_type'(cmd_bits | {CMD_W{cmd_count == '1 && 1'b0}});

endmodule

FILE: hdl/spmq_back.sv
// ----------------------------------------------------------------------------
// spmq_back
// Executes commands against the per-level queues and builds result words.
// ----------------------------------------------------------------------------
module spmq_back
   import spmq_pkg::*;
#(
   parameter int LEVELS    = 8,
   parameter int DEPTH     = 16,
   parameter int TASK_BITS = 16,
   parameter int OUT_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(LEVELS+1)-1:0]     active_levels,
   input  logic                            cmd_empty,
   input  cmd_type                         cmd_word,
   output logic                            cmd_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
   output logic                            rsp_push,
   output rsp_word_type                    rsp_word
);

   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH+1);
   localparam int HELD_W  = $clog2(LEVELS*DEPTH+1);
   localparam int ADDR_W  = $clog2(LEVELS*DEPTH);
   localparam int STORE_W = (TASK_BITS < TID_W) ? TASK_BITS : TID_W;

   be_state_type     state_ff, state_in;
   logic [PTR_W-1:0] head_ff [LEVELS];
   logic [PTR_W-1:0] head_in [LEVELS];
   logic [PTR_W-1:0] tail_ff [LEVELS];
   logic [PTR_W-1:0] tail_in [LEVELS];
   logic [CNT_W-1:0] cnt_ff  [LEVELS];
   logic [CNT_W-1:0] cnt_in  [LEVELS];
   logic [HELD_W-1:0] held_ff, held_in;

   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             ok_ff, ok_in;
   status_type       status_ff, status_in;
   logic             found_ff, found_in;
   logic             emit_ff, emit_in;
   rsp_word_type     meta_ff, meta_in;

   logic [STORE_W-1:0] task_mem [LEVELS*DEPTH];
   logic [STORE_W-1:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;

   logic [7:0]       cmd_lvl_wide;
   logic [LVL_W-1:0] cmd_idx;
   logic [LVL_W-1:0] sel_idx;
   logic [CNT_W-1:0] sel_cnt;
   logic             top_found;
   logic [LVL_W-1:0] top_idx;
   logic [PTR_W-1:0] top_head;
   logic [PTR_W-1:0] cmd_tail;
   logic [31:0]      held_wide, cnt_wide, prio_wide;
   logic [TID_W-1:0] head_ext;

   assign cmd_lvl_wide = 8'(cmd_word.lvl);
   assign cmd_idx      = cmd_lvl_wide[LVL_W-1:0];
   // exec reads the command level, look reads the saved level
   assign sel_idx      = (state_ff == BE_IDLE) ? cmd_idx : lvl_ff;
   assign sel_cnt      = cnt_ff[sel_idx];
   assign cmd_tail     = tail_ff[cmd_idx];
   assign top_head     = head_ff[top_idx];

   // highest non-empty level in use
   always_comb begin
      top_found = 1'b0;
      top_idx   = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (cnt_ff[i] != '0 && 32'(i) < 32'(active_levels)) begin
            top_found = 1'b1;
            top_idx   = LVL_W'(i);
         end
      end
   end

   assign held_wide = 32'(held_ff);
   assign cnt_wide  = 32'(sel_cnt);
   assign prio_wide = 32'(top_idx) + 32'd1;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      held_in   = held_ff;
      lvl_in    = lvl_ff;
      ok_in     = ok_ff;
      status_in = status_ff;
      found_in  = found_ff;
      meta_in   = meta_ff;
      emit_in   = 1'b0;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = ADDR_W'(32'(cmd_idx) * DEPTH + 32'(cmd_tail));
      mem_raddr = ADDR_W'(32'(top_idx) * DEPTH + 32'(top_head));
      unique case (state_ff)
         BE_IDLE: begin
            if (!cmd_empty && (32'(out_count) + 32'(emit_ff) < OUT_DEPTH)) begin
               cmd_pop   = 1'b1;
               state_in  = BE_LOOK;
               lvl_in    = cmd_idx;
               ok_in     = cmd_word.prio_ok;
               status_in = ST_OK;
               unique case (cmd_word.op)
                  OP_ADD: begin
                     if (!cmd_word.prio_ok) begin
                        status_in = ST_BAD_LEVEL;
                     end else if (sel_cnt == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we           = 1'b1;
                        tail_in[cmd_idx] = (cmd_tail == PTR_W'(DEPTH-1)) ?
                                           '0 : cmd_tail + 1'b1;
                        cnt_in[cmd_idx]  = sel_cnt + 1'b1;
                        held_in          = held_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (!top_found) begin
                        status_in = ST_EMPTY;
                     end else begin
                        head_in[top_idx] = (top_head == PTR_W'(DEPTH-1)) ?
                                           '0 : top_head + 1'b1;
                        cnt_in[top_idx]  = cnt_ff[top_idx] - 1'b1;
                        held_in          = held_ff - 1'b1;
                     end
                  end
                  OP_QUERY: ;
                  default: ;
               endcase
            end
         end
         BE_LOOK: begin
            mem_re                = 1'b1;
            found_in              = top_found;
            meta_in.head_task     = '0;
            meta_in.head_priority = top_found ? prio_wide[3:0] : '0;
            meta_in.total_count   = held_wide[7:0];
            meta_in.level_count   = ok_ff ? cnt_wide[4:0] : '0;
            meta_in.status        = status_ff;
            emit_in               = 1'b1;
            state_in              = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         held_ff  <= '0;
         emit_ff  <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         emit_ff  <= emit_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      ok_ff     <= ok_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      meta_ff   <= meta_in;
   end

   // task store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_waddr] <= cmd_word.tid[STORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= task_mem[mem_raddr];
      end
   end

   always_comb begin
      head_ext                = '0;
      head_ext[STORE_W-1:0]   = rd_data_ff;
      rsp_word                = meta_ff;
      rsp_word.head_task      = found_ff ? head_ext : '0;
   end

   assign rsp_push = emit_ff;

endmodule

FILE: hdl/spmq_checker.sv
// ----------------------------------------------------------------------------
// spmq_checker
// Port-level checks on the result side of the priority queue.
// ----------------------------------------------------------------------------
module spmq_checker
   import spmq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);

   // nothing waits right after reset
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result waiting after reset");

   // a removal from empty means no level in use holds a task
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.status == ST_EMPTY) |-> rsp_word.head_priority == '0)
      else $error("empty removal with a head level");

   // no head level means no head task
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.head_priority == '0) |-> rsp_word.head_task == '0)
      else $error("head task without a head level");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("stalled result changed");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);
